### design/fbpa_pkg.sv
// shared types, constants and widths of the fixed block pool allocator
// no dependencies; used by every design file
package fbpa_pkg;

  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned SIZE_W         = 13;
  localparam int unsigned CNT_W          = 11;
  localparam int unsigned OFF_W          = CNT_W + SIZE_W - 1;
  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned SIZE_LIMIT     = 4096;
  localparam int unsigned SIZE_RESET     = 16;
  localparam int unsigned COUNT_RESET    = 1024;
  localparam int unsigned COUNT_CAP      = (1 << CNT_W) - 1;

  typedef enum logic [1:0] {
    CFG_POOL_BASE   = 2'd0,
    CFG_BLOCK_SIZE  = 2'd1,
    CFG_BLOCK_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_INIT  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EXHAUSTED    = 3'd1,
    ST_NULL         = 3'd2,
    ST_RANGE        = 3'd3,
    ST_MISALIGNED   = 3'd4,
    ST_ALREADY_FREE = 3'd5,
    ST_FULL         = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC_RD,
    S_ALLOC_ADD,
    S_FREE_MUL,
    S_FREE_CHK,
    S_FREE_DIV,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PUSH,
    S_RESULT
  } state_e;

  // effective configuration, already clamped
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  count;
  } pool_cfg_t;

  typedef struct packed {
    logic             done;
    logic             exact;
    logic [CNT_W-1:0] quotient;
  } div_res_t;

endpackage

### design/fbpa_stack.sv
// free index stack: synchronous memory with a registered read
// entries below the low water mark read as their own position; uses fbpa_pkg
module fbpa_stack #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [IDX_W-1:0]           rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [IDX_W-1:0]           wr_addr_i,
  input  logic [IDX_W-1:0]           wr_data_i,
  input  logic [fbpa_pkg::CNT_W-1:0] low_mark_i,
  output logic [IDX_W-1:0]           rd_data_o
);

  localparam int unsigned CMP_W = (IDX_W > fbpa_pkg::CNT_W) ? IDX_W : fbpa_pkg::CNT_W;

  logic [IDX_W-1:0] mem_q [MAX_BLOCKS];
  logic [IDX_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q      <= mem_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // positions never written since the last init hold their own index
  assign rd_data_o = (CMP_W'(rd_addr_q) >= CMP_W'(low_mark_i)) ? rd_q : rd_addr_q;

endmodule

### design/fbpa_div.sv
// iterative restoring divider, one quotient bit per cycle
// gives the block index of an offset and whether it is aligned; uses fbpa_pkg
module fbpa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fbpa_pkg::OFF_W-1:0]  dividend_i,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor_i,
  output fbpa_pkg::div_res_t          res_o
);

  localparam int unsigned Q_W   = fbpa_pkg::CNT_W;
  localparam int unsigned D_W   = fbpa_pkg::SIZE_W + Q_W;
  localparam int unsigned CNT_B = $clog2(Q_W + 1);

  logic [fbpa_pkg::OFF_W-1:0] rem_q, rem_d;
  logic [D_W-1:0]             div_q, div_d;
  logic [Q_W-1:0]             quo_q, quo_d;
  logic [CNT_B-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       fits;

  assign fits = D_W'(rem_q) >= div_q;

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      div_d  = {1'b0, divisor_i, (Q_W-1)'(0)};
      quo_d  = '0;
      cnt_d  = CNT_B'(Q_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - fbpa_pkg::OFF_W'(div_q);
      end
      quo_d = {quo_q[Q_W-2:0], fits};
      div_d = div_q >> 1;
      cnt_d = cnt_q - CNT_B'(1);
      if (cnt_q == CNT_B'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign res_o.done     = done_q;
  assign res_o.exact    = (rem_q == '0);
  assign res_o.quotient = quo_q;

endmodule

### design/fbpa_ctrl.sv
// sequencer of the allocator: alloc, free checks, duplicate scan, init
// drives the stack memory and the divider; holds the output register; uses fbpa_pkg
module fbpa_ctrl #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fbpa_pkg::pool_cfg_t         cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  in_action_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] in_addr_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  out_status_o,
  output logic [fbpa_pkg::ADDR_W-1:0] out_granted_o,
  output logic [fbpa_pkg::CNT_W-1:0]  out_free_o,
  output logic                        rd_en_o,
  output logic [IDX_W-1:0]            rd_addr_o,
  input  logic [IDX_W-1:0]            rd_data_i,
  output logic                        wr_en_o,
  output logic [IDX_W-1:0]            wr_addr_o,
  output logic [IDX_W-1:0]            wr_data_o,
  output logic [fbpa_pkg::CNT_W-1:0]  low_mark_o,
  output logic                        div_start_o,
  output logic [fbpa_pkg::OFF_W-1:0]  div_dividend_o,
  input  fbpa_pkg::div_res_t          div_res_i
);

  localparam int unsigned CNT_W   = fbpa_pkg::CNT_W;
  localparam int unsigned ADDR_W  = fbpa_pkg::ADDR_W;
  localparam int unsigned MUL_A_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int unsigned PROD_W  = MUL_A_W + fbpa_pkg::SIZE_W;
  localparam int unsigned CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int unsigned FC_RST  =
    (MAX_BLOCKS < fbpa_pkg::COUNT_RESET) ? MAX_BLOCKS : fbpa_pkg::COUNT_RESET;

  fbpa_pkg::state_e  state_q, state_d;
  fbpa_pkg::status_e status_q, status_d;
  logic [1:0]        act_q, act_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] grant_q, grant_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CNT_W-1:0]  fc_q, fc_d;
  logic [CNT_W-1:0]  low_q, low_d;
  logic [CNT_W-1:0]  index_q, index_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_status_q;
  logic [ADDR_W-1:0] out_grant_q;
  logic [CNT_W-1:0]  out_free_q;
  logic              out_load;
  logic [MUL_A_W-1:0] mul_a;
  logic [ADDR_W:0]   pool_end;
  logic [CNT_W-1:0]  top;
  logic [CNT_W-1:0]  ptr_next;

  assign top      = fc_q - CNT_W'(1);
  assign ptr_next = ptr_q + CNT_W'(1);
  assign pool_end = {1'b0, cfg_i.base} + (ADDR_W + 1)'(prod_q);

  always_comb begin
    state_d        = state_q;
    status_d       = status_q;
    act_d          = act_q;
    addr_d         = addr_q;
    grant_d        = grant_q;
    prod_d         = prod_q;
    fc_d           = fc_q;
    low_d          = low_q;
    index_d        = index_q;
    ptr_d          = ptr_q;
    out_load       = 1'b0;
    in_ready_o     = 1'b0;
    rd_en_o        = 1'b0;
    rd_addr_o      = IDX_W'(top);
    wr_en_o        = 1'b0;
    wr_addr_o      = IDX_W'(fc_q);
    wr_data_o      = IDX_W'(index_q);
    div_start_o    = 1'b0;
    div_dividend_o = fbpa_pkg::OFF_W'(addr_q - cfg_i.base);
    mul_a          = MUL_A_W'(cfg_i.count);

    case (state_q)
      fbpa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d    = in_action_i;
          addr_d   = in_addr_i;
          grant_d  = '0;
          status_d = fbpa_pkg::ST_OK;
          state_d  = fbpa_pkg::S_DECODE;
        end
      end
      fbpa_pkg::S_DECODE: begin
        case (fbpa_pkg::action_e'(act_q))
          fbpa_pkg::ACT_ALLOC: begin
            if (fc_q == '0) begin
              status_d = fbpa_pkg::ST_EXHAUSTED;
              state_d  = fbpa_pkg::S_RESULT;
            end else begin
              rd_en_o = 1'b1;
              state_d = fbpa_pkg::S_ALLOC_RD;
            end
          end
          fbpa_pkg::ACT_FREE: state_d = fbpa_pkg::S_FREE_MUL;
          fbpa_pkg::ACT_INIT: begin
            fc_d    = cfg_i.count;
            low_d   = cfg_i.count;
            state_d = fbpa_pkg::S_RESULT;
          end
          default: state_d = fbpa_pkg::S_RESULT;
        endcase
      end
      fbpa_pkg::S_ALLOC_RD: begin
        mul_a   = MUL_A_W'(rd_data_i);
        prod_d  = PROD_W'(mul_a) * PROD_W'(cfg_i.size);
        state_d = fbpa_pkg::S_ALLOC_ADD;
      end
      fbpa_pkg::S_ALLOC_ADD: begin
        grant_d = cfg_i.base + ADDR_W'(prod_q);
        fc_d    = top;
        if (top < low_q) begin
          low_d = top;
        end
        state_d = fbpa_pkg::S_RESULT;
      end
      fbpa_pkg::S_FREE_MUL: begin
        prod_d  = PROD_W'(mul_a) * PROD_W'(cfg_i.size);
        state_d = fbpa_pkg::S_FREE_CHK;
      end
      fbpa_pkg::S_FREE_CHK: begin
        if (addr_q == '0) begin
          status_d = fbpa_pkg::ST_NULL;
          state_d  = fbpa_pkg::S_RESULT;
        end else if (addr_q < cfg_i.base || {1'b0, addr_q} >= pool_end) begin
          status_d = fbpa_pkg::ST_RANGE;
          state_d  = fbpa_pkg::S_RESULT;
        end else begin
          div_start_o = 1'b1;
          state_d     = fbpa_pkg::S_FREE_DIV;
        end
      end
      fbpa_pkg::S_FREE_DIV: begin
        if (div_res_i.done) begin
          index_d = div_res_i.quotient;
          ptr_d   = '0;
          if (!div_res_i.exact) begin
            status_d = fbpa_pkg::ST_MISALIGNED;
            state_d  = fbpa_pkg::S_RESULT;
          end else if (fc_q == '0) begin
            state_d = fbpa_pkg::S_PUSH;
          end else begin
            state_d = fbpa_pkg::S_SCAN_RD;
          end
        end
      end
      fbpa_pkg::S_SCAN_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = IDX_W'(ptr_q);
        state_d   = fbpa_pkg::S_SCAN_CMP;
      end
      fbpa_pkg::S_SCAN_CMP: begin
        if (CMP_W'(rd_data_i) == CMP_W'(index_q)) begin
          status_d = fbpa_pkg::ST_ALREADY_FREE;
          state_d  = fbpa_pkg::S_RESULT;
        end else begin
          ptr_d   = ptr_next;
          state_d = (ptr_next == fc_q) ? fbpa_pkg::S_PUSH : fbpa_pkg::S_SCAN_RD;
        end
      end
      fbpa_pkg::S_PUSH: begin
        if (fc_q >= cfg_i.count) begin
          status_d = fbpa_pkg::ST_FULL;
        end else begin
          wr_en_o = 1'b1;
          fc_d    = fc_q + CNT_W'(1);
        end
        state_d = fbpa_pkg::S_RESULT;
      end
      fbpa_pkg::S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = fbpa_pkg::S_IDLE;
        end
      end
      default: state_d = fbpa_pkg::S_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbpa_pkg::S_IDLE;
      fc_q        <= CNT_W'(FC_RST);
      low_q       <= CNT_W'(FC_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      low_q       <= low_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    act_q    <= act_d;
    addr_q   <= addr_d;
    grant_q  <= grant_d;
    prod_q   <= prod_d;
    index_q  <= index_d;
    ptr_q    <= ptr_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_grant_q  <= grant_q;
      out_free_q   <= fc_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_granted_o = out_grant_q;
  assign out_free_o    = out_free_q;
  assign low_mark_o    = low_q;

endmodule

### design/fixed_block_pool_allocator_top.sv
// fixed block pool allocator, top level: configuration registers and clamping
// instantiates fbpa_ctrl, fbpa_stack and fbpa_div; uses fbpa_pkg
// from accepted transaction to result: alloc reads the stack, multiplies and adds (exhausted skips
// these); init and unused action decode only; free multiplies, checks null and range, runs the divider,
// then reads and compares each entry scanned and pushes; one transaction at a time, the next accepted
// in the cycle after a result is loaded; reset: asynchronous, active low; registers and free count set
// at once, the stack reads as entry i holds i through a low water mark, no clearing pass
module fixed_block_pool_allocator_top #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // block_address
  input  logic [1:0]  s_axis_tuser_i,   // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // granted_address, free_remaining, zero pad
  output logic [2:0]  m_axis_tuser_o    // status
);

  localparam int unsigned IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W  = fbpa_pkg::CNT_W;
  localparam int unsigned SIZE_W = fbpa_pkg::SIZE_W;
  localparam int unsigned CAP    =
    (MAX_BLOCKS < fbpa_pkg::COUNT_CAP) ? MAX_BLOCKS : fbpa_pkg::COUNT_CAP;

  logic [31:0]       pool_base_q;
  logic [SIZE_W-1:0] block_size_q;
  logic [CNT_W-1:0]  block_count_q;
  fbpa_pkg::pool_cfg_t cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= '0;
      block_size_q  <= SIZE_W'(fbpa_pkg::SIZE_RESET);
      block_count_q <= CNT_W'(fbpa_pkg::COUNT_RESET);
    end else if (cfg_we_i) begin
      case (fbpa_pkg::cfg_idx_e'(cfg_index_i))
        fbpa_pkg::CFG_POOL_BASE:   pool_base_q   <= cfg_wdata_i;
        fbpa_pkg::CFG_BLOCK_SIZE:  block_size_q  <= cfg_wdata_i[SIZE_W-1:0];
        fbpa_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.base = pool_base_q;
    if (block_size_q == '0) begin
      cfg.size = SIZE_W'(1);
    end else if (block_size_q > SIZE_W'(fbpa_pkg::SIZE_LIMIT)) begin
      cfg.size = SIZE_W'(fbpa_pkg::SIZE_LIMIT);
    end else begin
      cfg.size = block_size_q;
    end
    if (block_count_q == '0) begin
      cfg.count = CNT_W'(1);
    end else if (block_count_q > CNT_W'(CAP)) begin
      cfg.count = CNT_W'(CAP);
    end else begin
      cfg.count = block_count_q;
    end
  end

  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [IDX_W-1:0]           rd_data;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [IDX_W-1:0]           wr_data;
  logic [CNT_W-1:0]           low_mark;
  logic                       div_start;
  logic [fbpa_pkg::OFF_W-1:0] div_dividend;
  fbpa_pkg::div_res_t         div_res;
  logic [31:0]                granted;
  logic [CNT_W-1:0]           free_rem;

  fbpa_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_action_i    (s_axis_tuser_i),
    .in_addr_i      (s_axis_tdata_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_status_o   (m_axis_tuser_o),
    .out_granted_o  (granted),
    .out_free_o     (free_rem),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .low_mark_o     (low_mark),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_res_i      (div_res)
  );

  fbpa_stack #(.MAX_BLOCKS(MAX_BLOCKS)) u_stack (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .low_mark_i (low_mark),
    .rd_data_o  (rd_data)
  );

  fbpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cfg.size),
    .res_o      (div_res)
  );

  assign m_axis_tdata_o = {5'b0, free_rem, granted};

endmodule

### design/fbpa_checker.sv
// port level checks of the fixed block pool allocator and their bind
// sees only the top level ports; uses fbpa_pkg status codes
module fbpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one transaction in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while previous transaction in flight");

  // exhausted means nothing free and nothing granted
  a_exhausted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == fbpa_pkg::ST_EXHAUSTED |->
      m_axis_tdata_o[42:32] == '0 && m_axis_tdata_o[31:0] == '0)
    else $error("exhausted with free blocks or an address");

  // a granted address only comes with status ok
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[31:0] != '0 |->
      m_axis_tuser_o == fbpa_pkg::ST_OK)
    else $error("address granted with an error status");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);

### bench/tb.sv
// testbench for fixed_block_pool_allocator_top: directed checks, then random traffic with idling
// predicts every result from its own copy of the free stack and registers; uses fbpa_pkg
`timescale 1ns / 1ps

module tb;

  localparam int unsigned POOL_DEPTH     = fbpa_pkg::MAX_BLOCKS_DEF;
  localparam int unsigned IDX_W          = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W          = fbpa_pkg::CNT_W;
  localparam int unsigned SIZE_W         = fbpa_pkg::SIZE_W;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  typedef struct {
    fbpa_pkg::status_e status;
    logic [31:0]       granted;
    logic [CNT_W-1:0]  remaining;
  } pool_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  fbpa_pkg::cfg_idx_e cfg_index = fbpa_pkg::CFG_POOL_BASE;
  logic [31:0]        cfg_wdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;   // block_address
  logic [1:0]         s_axis_tuser = '0;   // action
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [47:0]        m_axis_tdata;        // granted_address, free_remaining, zero pad
  logic [2:0]         m_axis_tuser;        // status

  // mirror of the block's registers and free stack
  logic [31:0]       cfg_base;
  logic [SIZE_W-1:0] cfg_size;
  logic [CNT_W-1:0]  cfg_count;
  logic [IDX_W-1:0]  free_idx [POOL_DEPTH];
  logic [CNT_W-1:0]  free_total;

  pool_result_t expected_results[$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles = 0;

  fixed_block_pool_allocator_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned usable_size();
    if (cfg_size == 0) return 1;
    if (cfg_size > fbpa_pkg::SIZE_LIMIT) return fbpa_pkg::SIZE_LIMIT;
    return 32'(cfg_size);
  endfunction

  function automatic int unsigned usable_blocks();
    if (cfg_count == 0) return 1;
    if (cfg_count > POOL_DEPTH) return POOL_DEPTH;
    return 32'(cfg_count);
  endfunction

  function automatic pool_result_t pool_predict(input logic [1:0] act, input logic [31:0] addr);
    pool_result_t     res;
    int unsigned      sz;
    int unsigned      cnt;
    logic [63:0]      pool_end;
    logic [31:0]      offset;
    logic [31:0]      index;
    logic [CNT_W-1:0] top;
    bit               seen;
    sz = usable_size();
    cnt = usable_blocks();
    res.status = fbpa_pkg::ST_OK;
    res.granted = '0;
    case (act)
      fbpa_pkg::ACT_ALLOC: begin
        if (free_total == 0) begin
          res.status = fbpa_pkg::ST_EXHAUSTED;
        end else begin
          top = free_total - 1'b1;
          res.granted = cfg_base + free_idx[top] * sz;
          free_total = top;
        end
      end
      fbpa_pkg::ACT_FREE: begin
        pool_end = 64'(cfg_base) + 64'(cnt) * 64'(sz);
        if (addr == 0) begin
          res.status = fbpa_pkg::ST_NULL;
        end else if (addr < cfg_base || 64'(addr) >= pool_end) begin
          res.status = fbpa_pkg::ST_RANGE;
        end else begin
          offset = addr - cfg_base;
          if (offset % sz != 0) begin
            res.status = fbpa_pkg::ST_MISALIGNED;
          end else begin
            index = offset / sz;
            seen = 1'b0;
            for (int i = 0; i < free_total; i++)
              if (free_idx[i] == index) seen = 1'b1;
            if (seen) res.status = fbpa_pkg::ST_ALREADY_FREE;
            else if (free_total >= cnt) res.status = fbpa_pkg::ST_FULL;
            else begin
              free_idx[free_total] = index[IDX_W-1:0];
              free_total = free_total + 1'b1;
            end
          end
        end
      end
      fbpa_pkg::ACT_INIT: begin
        for (int i = 0; i < POOL_DEPTH; i++) free_idx[i] = i[IDX_W-1:0];
        free_total = cnt[CNT_W-1:0];
      end
      default: ;
    endcase
    res.remaining = free_total;
    return res;
  endfunction

  task automatic send_request(input logic [1:0] act, input logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(pool_predict(act, addr));
  endtask

  task automatic wait_pool_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic pool_configure(input logic [31:0] base, input logic [31:0] size,
                                input logic [31:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= fbpa_pkg::CFG_POOL_BASE;
    cfg_wdata <= base;
    @(posedge clk_i);
    cfg_base  = base;
    cfg_index <= fbpa_pkg::CFG_BLOCK_SIZE;
    cfg_wdata <= size;
    @(posedge clk_i);
    cfg_size  = size[SIZE_W-1:0];
    cfg_index <= fbpa_pkg::CFG_BLOCK_COUNT;
    cfg_wdata <= count;
    @(posedge clk_i);
    cfg_count = count[CNT_W-1:0];
    cfg_we    <= 1'b0;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    pool_result_t want;
    m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d", $time,
                 m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
        if (m_axis_tdata[31:0] != want.granted)
          report_mismatch("granted_address", want.granted, m_axis_tdata[31:0]);
        if (m_axis_tdata[32 +: CNT_W] != want.remaining)
          report_mismatch("free_remaining", 32'(want.remaining), 32'(m_axis_tdata[32 +: CNT_W]));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // reset pool: base 0, size 16, every block free
  task automatic test_reset_state();
    send_request(fbpa_pkg::ACT_ALLOC, 32'h0);
    send_request(fbpa_pkg::ACT_FREE, 32'h0000_3FF0);
    send_request(fbpa_pkg::ACT_FREE, 32'h0);
    send_request(fbpa_pkg::ACT_FREE, 32'h0000_3FF8);
    send_request(fbpa_pkg::ACT_FREE, 32'h0000_4000);
    send_request(fbpa_pkg::ACT_FREE, 32'h0000_0010);
    send_request(fbpa_pkg::ACT_FREE, 32'hFFFF_FFFF);
  endtask

  // zero size and count clamp to one; full needs a shrunk count without init
  task automatic test_exhaust_and_full();
    wait_pool_idle();
    pool_configure(32'h1000, 32'd0, 32'd0);
    send_request(fbpa_pkg::ACT_INIT, 32'hFFFF_FFFF);
    send_request(fbpa_pkg::ACT_ALLOC, 32'h0);
    send_request(fbpa_pkg::ACT_ALLOC, 32'h0);
    send_request(fbpa_pkg::ACT_FREE, 32'h1000);
    wait_pool_idle();
    pool_configure(32'h1000, 32'd16, 32'd4);
    send_request(fbpa_pkg::ACT_INIT, 32'h0);
    repeat (4) send_request(fbpa_pkg::ACT_ALLOC, 32'h0);
    send_request(fbpa_pkg::ACT_FREE, 32'h1030);
    send_request(fbpa_pkg::ACT_FREE, 32'h1020);
    wait_pool_idle();
    pool_configure(32'h1000, 32'd16, 32'd2);
    send_request(fbpa_pkg::ACT_FREE, 32'h1000);
  endtask

  // pool running past the top of the address space, sizes and counts above their caps
  task automatic test_address_wrap();
    wait_pool_idle();
    pool_configure(32'hFFFF_F000, 32'd8000, 32'd2047);
    send_request(fbpa_pkg::ACT_INIT, 32'h0);
    send_request(fbpa_pkg::ACT_ALLOC, 32'h0);
    send_request(fbpa_pkg::ACT_FREE, 32'h003F_E000);
    send_request(fbpa_pkg::ACT_FREE, 32'hFFFF_F800);
    send_request(fbpa_pkg::ACT_FREE, 32'hFFFF_F000);
    send_request(ACT_UNUSED, 32'hA5A5_5A5A);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    int          sent;
    int          seg_len;
    int          r;
    int unsigned sz;
    int unsigned cnt;
    int unsigned k;
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] count;
    logic [1:0]  act;
    logic [31:0] addr;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_pool_idle();
      r = $urandom_range(99);
      if (r < 70) size = $urandom_range(64, 1);
      else if (r < 80) size = fbpa_pkg::SIZE_LIMIT;
      else if (r < 85) size = 0;
      else if (r < 92) size = $urandom_range(8191, 4097);
      else size = $urandom_range(4096, 1);
      r = $urandom_range(99);
      if (r < 78) count = $urandom_range(16, 1);
      else if (r < 86) count = $urandom_range(200, 17);
      else if (r < 92) count = POOL_DEPTH;
      else if (r < 96) count = $urandom_range(2047, 1025);
      else count = 0;
      r = $urandom_range(99);
      if (r < 15) base = 32'h0;
      else if (r < 30) base = 32'hFFFF_FFFF - $urandom_range(65535, 0);
      else base = $urandom;
      pool_configure(base, size, count);
      sz = usable_size();
      cnt = usable_blocks();
      seg_len = (cnt > 200) ? 12 : 40;
      // now and then keep the old stack under the new registers
      if ($urandom_range(99) < 80) begin
        send_request(fbpa_pkg::ACT_INIT, $urandom);
        sent++;
      end
      repeat (seg_len) begin
        r = $urandom_range(99);
        if (r < 45) act = fbpa_pkg::ACT_ALLOC;
        else if (r < 93) act = fbpa_pkg::ACT_FREE;
        else if (r < 97) act = fbpa_pkg::ACT_INIT;
        else act = ACT_UNUSED;
        addr = $urandom;
        if (act == fbpa_pkg::ACT_FREE) begin
          r = $urandom_range(99);
          k = $urandom_range(cnt - 1, 0);
          if (r < 70) addr = cfg_base + k * sz;
          else if (r < 78) addr = cfg_base + k * sz + $urandom_range(sz - 1, 0);
          else if (r < 84) addr = cfg_base + cnt * sz + $urandom_range(255, 0);
          else if (r < 88) addr = cfg_base - 1 - $urandom_range(255, 0);
          else if (r < 92) addr = 32'h0;
        end
        send_request(act, addr);
        sent++;
      end
    end
  endtask

  initial begin
    cfg_base = '0;
    cfg_size = SIZE_W'(fbpa_pkg::SIZE_RESET);
    cfg_count = CNT_W'(fbpa_pkg::COUNT_RESET);
    for (int i = 0; i < POOL_DEPTH; i++) free_idx[i] = i[IDX_W-1:0];
    free_total = CNT_W'(usable_blocks());
    send_idle_pct = 6;
    recv_stall_pct = 62;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_exhaust_and_full();
    test_address_wrap();
    test_random_traffic(6, 62, 410);
    test_random_traffic(62, 6, 410);
    test_random_traffic(0, 0, 410);
    wait_pool_idle();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
